[hw/rtl/gsw_pkg.sv]
// shared types, constants and helpers for the gait symmetry window
package gsw_pkg;

    localparam int WINDOW_DEPTH  = 32;
    localparam int EMIT_INTERVAL = 10;

    localparam int SEEDS  = (EMIT_INTERVAL - 1 > WINDOW_DEPTH) ? WINDOW_DEPTH
                                                               : EMIT_INTERVAL - 1;
    localparam int PTR_W  = $clog2(WINDOW_DEPTH);
    localparam int FILL_W = $clog2(WINDOW_DEPTH + 1);
    localparam int ICNT_W = $clog2(EMIT_INTERVAL) + 1;
    localparam int SUM_W  = 17 + FILL_W;
    localparam int PROD_W = SUM_W + FILL_W;
    localparam int DEN_W  = PROD_W + 2;
    localparam int QUOT_W = 20;
    localparam int REM_W  = DEN_W + QUOT_W;
    localparam int QCNT_W = $clog2(QUOT_W);

    localparam logic [15:0] SEED_STANCE  = 16'd343;
    localparam logic [15:0] SEED_SWING   = 16'd229;
    localparam logic [15:0] SEED_CADENCE = 16'd105;
    localparam logic [10:0] SI_FULL      = 11'd2000;
    localparam logic [7:0]  MODE_FAST_SPM = 8'd130;

    localparam logic [1:0] MODE_NORMAL = 2'd1;
    localparam logic [1:0] MODE_FAST   = 2'd2;

    typedef struct packed {
        logic [15:0] stance;
        logic [15:0] swing;
        logic [16:0] rate_mag;
        logic [15:0] cadence;
        logic        valid;
        logic        odd;
    } gsw_entry_t;

    typedef struct packed {
        logic             en;
        logic [PTR_W-1:0] addr;
        gsw_entry_t       data;
    } gsw_wr_t;

    typedef struct packed {
        logic             en;
        logic [PTR_W-1:0] addr;
    } gsw_rd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WALK,
        ST_LAST,
        ST_PREP,
        ST_FORM,
        ST_DIV,
        ST_DONE
    } gsw_state_t;

    typedef enum logic [1:0] {
        OP_STANCE,
        OP_SWING,
        OP_RATE,
        OP_CADENCE
    } gsw_op_t;

    function automatic gsw_entry_t seed_entry(input logic odd);
        gsw_entry_t e;
        e.stance   = SEED_STANCE;
        e.swing    = SEED_SWING;
        e.rate_mag = '0;
        e.cadence  = SEED_CADENCE;
        e.valid    = 1'b1;
        e.odd      = odd;
        return e;
    endfunction

    // wrap a sum of two indexes below twice the depth
    function automatic logic [PTR_W-1:0] wrap_idx(input logic [FILL_W:0] s);
        logic [FILL_W:0] r;
        r = (s >= (FILL_W+1)'(WINDOW_DEPTH)) ? s - (FILL_W+1)'(WINDOW_DEPTH) : s;
        return r[PTR_W-1:0];
    endfunction

endpackage

[hw/rtl/gsw_store.sv]
// circular window store of step records with per-entry written flags
module gsw_store import gsw_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  gsw_wr_t    wr,
    input  gsw_rd_t    rd,
    output gsw_entry_t rd_data,
    output logic       rd_valid
);

    gsw_entry_t              mem [WINDOW_DEPTH];
    logic [WINDOW_DEPTH-1:0] written_reg;
    gsw_entry_t              mem_q_reg;
    logic                    wflag_q_reg;
    logic                    seed_q_reg;
    logic                    odd_q_reg;
    logic                    rd_valid_reg;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
        mem_q_reg   <= mem[rd.addr];
        wflag_q_reg <= written_reg[rd.addr];
        seed_q_reg  <= ((FILL_W+1)'(rd.addr) < (FILL_W+1)'(SEEDS));
        odd_q_reg   <= rd.addr[0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            written_reg  <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            rd_valid_reg <= rd.en;
            if (wr.en) begin
                written_reg[wr.addr] <= 1'b1;
            end
        end
    end

    // unwritten entries read as their reset contents
    always_comb begin
        if (wflag_q_reg) begin
            rd_data = mem_q_reg;
        end else if (seed_q_reg) begin
            rd_data = seed_entry(odd_q_reg);
        end else begin
            rd_data = '0;
        end
    end

    assign rd_valid = rd_valid_reg;

endmodule

[hw/rtl/gsw_divider.sv]
// shared restoring divider, one quotient bit per cycle
module gsw_divider import gsw_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [REM_W-1:0]  num,
    input  logic [DEN_W-1:0]  den,
    output logic              busy,
    output logic              done,
    output logic [QUOT_W-1:0] quot
);

    logic              busy_reg;
    logic [QCNT_W-1:0] k_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [REM_W-1:0]  dsh_reg;
    logic [QUOT_W-1:0] q_reg;
    logic              ge;

    assign ge = (rem_reg >= dsh_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else if (start) begin
            busy_reg <= 1'b1;
        end else if (busy_reg && k_reg == '0) begin
            busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= num;
            dsh_reg <= REM_W'(den) << (QUOT_W - 1);
            k_reg   <= QCNT_W'(QUOT_W - 1);
            q_reg   <= '0;
        end else if (busy_reg) begin
            if (ge) begin
                rem_reg <= rem_reg - dsh_reg;
            end
            dsh_reg <= dsh_reg >> 1;
            k_reg   <= k_reg - 1'b1;
            q_reg   <= {q_reg[QUOT_W-2:0], ge};
        end
    end

    assign busy = busy_reg;
    assign done = busy_reg && (k_reg == '0);
    // full quotient holds from the cycle after done
    assign quot = q_reg;

endmodule

[hw/rtl/gait_symmetry_window.sv]
// top level of the gait symmetry window: sequencer, sums and result register
//
// channel  dir  handshake          payload
// s_       in   s_tvalid/s_tready  s_tdata step record, s_tuser record_valid
// m_       out  m_tvalid/m_tready  m_tdata snapshot, m_tuser cadence_mode
//
// a step that yields no snapshot leaves the block idle and ready for the next one
// a snapshot step runs through the accept, the window walk reading one record per
// cycle from the store port and a last state for the final read; then three
// symmetry indexes and the cadence mean share one divider that makes one quotient
// bit per cycle
// reset is synchronous; the window comes up holding the seed records
// a pending snapshot waits in the output register while new steps are taken;
// the next snapshot holds in its last step until that register is free
module gait_symmetry_window import gsw_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // step_number[31:0], heel_time_ms[63:32], stance_ms[79:64], swing_ms[95:80],
    // peak_rate_dps[111:96], step_rate[127:112]
    input  logic [127:0] s_tdata,
    // record_valid[0]
    input  logic [0:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // anchor_step[31:0], anchor_time_ms[63:32], stance_sym_x10[74:64],
    // swing_sym_x10[85:75], rate_sym_x10[96:86], avg_rate_x10[116:97],
    // window_steps[124:117], zero fill[127:125]
    output logic [127:0] m_tdata,
    // cadence_mode[1:0]
    output logic [1:0]   m_tuser
);

    // sequencer state
    gsw_state_t        state_reg, state_next;
    gsw_op_t           op_reg;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [PTR_W-1:0]  head_reg, head_next;
    logic [ICNT_W-1:0] icnt_reg, icnt_next;
    logic [FILL_W-1:0] cnt_reg;

    // window sums
    logic [SUM_W-1:0]  st_o_reg, st_e_reg, sw_o_reg, sw_e_reg, rt_o_reg, rt_e_reg;
    logic [SUM_W-1:0]  cad_reg;
    logic [FILL_W-1:0] n_o_reg, n_e_reg;

    // per-index operands and results
    logic [PROD_W-1:0] a_reg, b_reg;
    logic [REM_W-1:0]  cnum_reg;
    logic [DEN_W-1:0]  cden_reg;
    logic              zero_reg;
    logic [1:0]        mode_reg;
    logic [10:0]       si_st_reg, si_sw_reg, si_rt_reg;
    logic [31:0]       anc_step_reg, anc_time_reg;

    // output register
    logic              m_valid_reg;
    logic [127:0]      m_data_reg;
    logic [1:0]        m_user_reg;

    // control decodes
    logic              accept, snap, out_free, issue, div_start;
    logic [REM_W-1:0]  div_num;
    logic [DEN_W-1:0]  div_den;
    logic              div_busy, div_done;
    logic [QUOT_W-1:0] div_q;

    gsw_wr_t           wr;
    gsw_rd_t           rd;
    gsw_entry_t        rd_data;
    logic              rd_valid;

    // operand selection for the index being formed
    logic [SUM_W-1:0]  sel_o, sel_e;
    logic [FILL_W-1:0] mx_o, mx_e;
    logic [DEN_W-1:0]  sum_ab;
    logic [PROD_W-1:0] diff_ab;
    logic [10:0]       si_cap;
    logic [7:0]        win_steps;
    logic [16:0]       raw_mag;

    assign accept   = s_tvalid && s_tready;
    assign snap     = (icnt_reg + 1'b1) == ICNT_W'(EMIT_INTERVAL);
    assign out_free = !m_valid_reg || m_tready;

    // magnitude of the signed peak rate, -32768 maps to 32768
    assign raw_mag = s_tdata[111] ? (17'h10000 - {1'b0, s_tdata[111:96]})
                                  : {1'b0, s_tdata[111:96]};

    always_comb begin
        wr.en            = accept;
        wr.addr          = wrap_idx((FILL_W+1)'(head_reg) + (FILL_W+1)'(fill_reg));
        wr.data.stance   = s_tdata[79:64];
        wr.data.swing    = s_tdata[95:80];
        wr.data.rate_mag = raw_mag;
        wr.data.cadence  = s_tdata[127:112];
        wr.data.valid    = s_tuser[0];
        wr.data.odd      = s_tdata[0];
        rd.en            = issue;
        rd.addr          = wrap_idx((FILL_W+1)'(head_reg) + (FILL_W+1)'(cnt_reg));
    end

    gsw_store u_store (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr       (wr),
        .rd       (rd),
        .rd_data  (rd_data),
        .rd_valid (rd_valid)
    );

    always_comb begin
        case (op_reg)
            OP_STANCE: begin
                sel_o = st_o_reg;
                sel_e = st_e_reg;
            end
            OP_SWING: begin
                sel_o = sw_o_reg;
                sel_e = sw_e_reg;
            end
            default: begin
                sel_o = rt_o_reg;
                sel_e = rt_e_reg;
            end
        endcase
        mx_o    = (n_o_reg == '0) ? FILL_W'(1) : n_o_reg;
        mx_e    = (n_e_reg == '0) ? FILL_W'(1) : n_e_reg;
        sum_ab  = DEN_W'(a_reg) + DEN_W'(b_reg);
        diff_ab = (a_reg > b_reg) ? a_reg - b_reg : b_reg - a_reg;
    end

    // divider operands: index from the products, or the cadence mean
    always_comb begin
        if (op_reg != OP_CADENCE) begin
            div_num = REM_W'(diff_ab) * REM_W'(4000) + REM_W'(sum_ab);
            div_den = sum_ab << 1;
        end else begin
            div_num = cnum_reg;
            div_den = cden_reg;
        end
    end

    gsw_divider u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .busy    (div_busy),
        .done    (div_done),
        .quot    (div_q)
    );

    assign si_cap    = (div_q > QUOT_W'(SI_FULL)) ? SI_FULL : div_q[10:0];
    assign win_steps = (9'(fill_reg) > 9'd255) ? 8'd255 : 8'(fill_reg);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept && snap) begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK: begin
                if ((cnt_reg + 1'b1) == fill_reg) begin
                    state_next = ST_LAST;
                end
            end
            ST_LAST: begin
                state_next = ST_PREP;
            end
            ST_PREP: begin
                state_next = (op_reg == OP_CADENCE) ? ST_FORM : ST_FORM;
            end
            ST_FORM: begin
                state_next = div_start ? ST_DIV : ST_DONE;
            end
            ST_DIV: begin
                if (div_done) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (op_reg != OP_CADENCE) begin
                    state_next = ST_PREP;
                end else if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control outputs
    always_comb begin
        s_tready  = (state_reg == ST_IDLE);
        issue     = (state_reg == ST_WALK);
        div_start = (state_reg == ST_FORM) &&
                    ((op_reg == OP_CADENCE) ? (cden_reg != '0) : (sum_ab != '0));
    end

    // window bookkeeping
    always_comb begin
        fill_next = fill_reg;
        head_next = head_reg;
        icnt_next = icnt_reg;
        if (accept) begin
            if (fill_reg < FILL_W'(WINDOW_DEPTH)) begin
                fill_next = fill_reg + 1'b1;
            end else begin
                head_next = wrap_idx((FILL_W+1)'(head_reg) + (FILL_W+1)'(1));
            end
            icnt_next = snap ? '0 : icnt_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            fill_reg    <= FILL_W'(SEEDS);
            head_reg    <= '0;
            icnt_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            head_reg  <= head_next;
            icnt_reg  <= icnt_next;
            if (state_reg == ST_DONE && op_reg == OP_CADENCE && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                anc_step_reg <= s_tdata[31:0];
                anc_time_reg <= s_tdata[63:32];
                cnt_reg      <= '0;
                op_reg       <= OP_STANCE;
                {st_o_reg, st_e_reg, sw_o_reg, sw_e_reg} <= '0;
                {rt_o_reg, rt_e_reg, cad_reg}            <= '0;
                {n_o_reg, n_e_reg}                       <= '0;
            end
            ST_WALK: begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            ST_PREP: begin
                a_reg    <= PROD_W'(sel_o) * PROD_W'(mx_e);
                b_reg    <= PROD_W'(sel_e) * PROD_W'(mx_o);
                cnum_reg <= REM_W'(cad_reg) * REM_W'(20) + REM_W'(fill_reg);
                cden_reg <= DEN_W'(fill_reg) << 1;
                mode_reg <= ((fill_reg != '0) &&
                             (cad_reg >= SUM_W'(fill_reg) * SUM_W'(MODE_FAST_SPM)))
                            ? MODE_FAST : MODE_NORMAL;
            end
            ST_FORM: begin
                zero_reg <= !div_start;
            end
            ST_DONE: begin
                case (op_reg)
                    OP_STANCE:  si_st_reg <= zero_reg ? '0 : si_cap;
                    OP_SWING:   si_sw_reg <= zero_reg ? '0 : si_cap;
                    OP_RATE:    si_rt_reg <= zero_reg ? '0 : si_cap;
                    default: begin
                    end
                endcase
                if (op_reg != OP_CADENCE) begin
                    op_reg <= gsw_op_t'(op_reg + 1'b1);
                end
            end
            default: begin
            end
        endcase

        // sums take each valid record as its read data returns
        if (rd_valid && rd_data.valid) begin
            if (rd_data.odd) begin
                st_o_reg <= st_o_reg + SUM_W'(rd_data.stance);
                sw_o_reg <= sw_o_reg + SUM_W'(rd_data.swing);
                rt_o_reg <= rt_o_reg + SUM_W'(rd_data.rate_mag);
                n_o_reg  <= n_o_reg + 1'b1;
            end else begin
                st_e_reg <= st_e_reg + SUM_W'(rd_data.stance);
                sw_e_reg <= sw_e_reg + SUM_W'(rd_data.swing);
                rt_e_reg <= rt_e_reg + SUM_W'(rd_data.rate_mag);
                n_e_reg  <= n_e_reg + 1'b1;
            end
            cad_reg <= cad_reg + SUM_W'(rd_data.cadence);
        end

        // result register loads when the cadence mean is done and the output register is free
        if (state_reg == ST_DONE && op_reg == OP_CADENCE && out_free) begin
            m_data_reg <= {3'b000, win_steps,
                           zero_reg ? 20'd0 : div_q,
                           si_rt_reg, si_sw_reg, si_st_reg,
                           anc_time_reg, anc_step_reg};
            m_user_reg <= mode_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    // the window never holds more than its depth
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= FILL_W'(WINDOW_DEPTH))
        else $error("fill count beyond window depth");

    // the head only moves once the window is full
    a_head_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (head_reg != '0) |-> (fill_reg == FILL_W'(WINDOW_DEPTH)))
        else $error("head moved before window full");

    // the divider runs throughout the divide state
    a_div_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> div_busy)
        else $error("divide state without running divider");

    // no new request is taken while a snapshot is being worked out
    a_no_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !s_tready)
        else $error("request taken mid snapshot");

    // results stay in range
    a_si_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[74:64] <= SI_FULL && m_tdata[85:75] <= SI_FULL &&
                      m_tdata[96:86] <= SI_FULL &&
                      (m_tuser == MODE_NORMAL || m_tuser == MODE_FAST)))
        else $error("snapshot field out of range");

endmodule

[sim/tb_top.sv]
// self-checking testbench for the gait symmetry window
module tb_top;
    import gsw_pkg::*;

    // one step record as driven on the input stream
    typedef struct {
        logic [31:0] step_number;
        logic [31:0] heel_time_ms;
        logic [15:0] stance_ms;
        logic [15:0] swing_ms;
        logic [15:0] peak_rate_dps;
        logic [15:0] step_rate;
        logic        record_valid;
    } step_rec_t;

    // one snapshot as seen on the result stream
    typedef struct {
        logic [31:0] anchor_step;
        logic [31:0] anchor_time_ms;
        logic [10:0] stance_sym_x10;
        logic [10:0] swing_sym_x10;
        logic [10:0] rate_sym_x10;
        logic [19:0] avg_rate_x10;
        logic [7:0]  window_steps;
        logic [1:0]  cadence_mode;
    } snapshot_t;

    // window slot held by the predictor
    typedef struct {
        int unsigned stance;
        int unsigned swing;
        int unsigned rate_mag;
        int unsigned cadence;
        bit          valid;
        bit          odd;
    } slot_t;

    // a directed row: record plus an optional typed-in window count
    typedef struct {
        step_rec_t rec;
        bit        has_fixed;
        logic [7:0] fixed_steps;
    } row_t;

    localparam int LIMIT_CYCLES = 1_500_000;
    localparam int N_RANDOM     = 800;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [127:0] s_tdata;
    logic [0:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [127:0] m_tdata;
    logic [1:0]   m_tuser;

    gait_symmetry_window dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // predictor state
    slot_t       win [WINDOW_DEPTH];
    int unsigned head_idx;
    int unsigned fill_cnt;
    int unsigned steps_since_snap;

    snapshot_t   snap_q[$];
    int          fixed_mode_q[$];   // -1 when no typed-in value
    int          fixed_steps_q[$];
    int          mismatches;
    int          send_idle_pct;
    int          recv_idle_pct;
    bit          hold_recv;
    int          cycle_cnt;

    function automatic longint unsigned symmetry_x10(longint unsigned so, longint unsigned no,
                                                    longint unsigned se, longint unsigned ne);
        longint unsigned a, b, den, diff, q;
        a = so * ((ne != 0) ? ne : 1);
        b = se * ((no != 0) ? no : 1);
        den = a + b;
        diff = (a > b) ? a - b : b - a;
        if (den == 0) return 0;
        q = (4000 * diff + den) / (2 * den);
        return (q > 2000) ? 2000 : q;
    endfunction

    task automatic reset_window();
        for (int i = 0; i < WINDOW_DEPTH; i++) begin
            win[i] = '{default: 0};
            if (i < SEEDS) begin
                win[i].stance  = 343;
                win[i].swing   = 229;
                win[i].cadence = 105;
                win[i].valid   = 1'b1;
                win[i].odd     = i[0];
            end
        end
        head_idx = 0;
        fill_cnt = SEEDS;
        steps_since_snap = 0;
    endtask

    // store the record; return 1 and the snapshot when one falls due
    function automatic bit take_step(input step_rec_t r, output snapshot_t s);
        int unsigned tail, idx;
        longint unsigned st_o, st_e, sw_o, sw_e, rt_o, rt_e, n_o, n_e, cad, w;
        st_o = 0; st_e = 0; sw_o = 0; sw_e = 0; rt_o = 0; rt_e = 0;
        n_o = 0; n_e = 0; cad = 0;
        tail = (head_idx + fill_cnt) % WINDOW_DEPTH;
        win[tail].stance   = 32'(r.stance_ms);
        win[tail].swing    = 32'(r.swing_ms);
        win[tail].rate_mag = r.peak_rate_dps[15] ? 32'h10000 - 32'(r.peak_rate_dps)
                                                 : 32'(r.peak_rate_dps);
        win[tail].cadence  = 32'(r.step_rate);
        win[tail].valid    = r.record_valid;
        win[tail].odd      = r.step_number[0];
        if (fill_cnt < WINDOW_DEPTH) fill_cnt++;
        else head_idx = (head_idx + 1) % WINDOW_DEPTH;
        steps_since_snap++;
        s = '{default: 0};
        if (steps_since_snap < EMIT_INTERVAL) return 1'b0;
        steps_since_snap = 0;
        for (int i = 0; i < fill_cnt; i++) begin
            idx = (head_idx + i) % WINDOW_DEPTH;
            if (!win[idx].valid) continue;
            if (win[idx].odd) begin
                st_o += win[idx].stance; sw_o += win[idx].swing;
                rt_o += win[idx].rate_mag; n_o++;
            end else begin
                st_e += win[idx].stance; sw_e += win[idx].swing;
                rt_e += win[idx].rate_mag; n_e++;
            end
            cad += win[idx].cadence;
        end
        w = fill_cnt;
        s.anchor_step    = r.step_number;
        s.anchor_time_ms = r.heel_time_ms;
        s.stance_sym_x10 = 11'(symmetry_x10(st_o, n_o, st_e, n_e));
        s.swing_sym_x10  = 11'(symmetry_x10(sw_o, n_o, sw_e, n_e));
        s.rate_sym_x10   = 11'(symmetry_x10(rt_o, n_o, rt_e, n_e));
        s.avg_rate_x10   = 20'((w != 0) ? (20 * cad + w) / (2 * w) : 0);
        s.window_steps   = 8'((w > 255) ? 255 : w);
        s.cadence_mode   = (w != 0 && cad >= 130 * w) ? MODE_FAST : MODE_NORMAL;
        return 1'b1;
    endfunction

    function automatic step_rec_t random_record(input int unsigned step_no);
        step_rec_t r;
        r.step_number  = ($urandom_range(0, 9) == 0) ? $urandom : step_no;
        r.heel_time_ms = $urandom;
        case ($urandom_range(0, 3))
            0: begin
                r.stance_ms = 16'($urandom);
                r.swing_ms  = 16'($urandom);
            end
            1: begin
                r.stance_ms = 16'hFFFF;
                r.swing_ms  = 16'($urandom_range(0, 3));
            end
            default: begin
                r.stance_ms = 16'($urandom_range(250, 900));
                r.swing_ms  = 16'($urandom_range(150, 600));
            end
        endcase
        r.peak_rate_dps = ($urandom_range(0, 3) == 0) ? 16'(16'h8000 + $urandom_range(0, 3))
                                                      : 16'($urandom);
        r.step_rate     = ($urandom_range(0, 2) == 0) ? 16'($urandom)
                                                      : 16'($urandom_range(80, 180));
        r.record_valid  = ($urandom_range(0, 4) != 0);
        return r;
    endfunction

    // hand one record to the block, predicting its outcome at acceptance
    task automatic send_record(input step_rec_t r, input int fixed_mode, input int fixed_steps);
        snapshot_t s;
        while (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {r.step_rate, r.peak_rate_dps, r.swing_ms, r.stance_ms,
                     r.heel_time_ms, r.step_number};
        s_tuser  <= r.record_valid;
        do @(posedge aclk); while (!s_tready);
        if (take_step(r, s)) begin
            snap_q.push_back(s);
            fixed_mode_q.push_back(fixed_mode);
            fixed_steps_q.push_back(fixed_steps);
        end
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (snap_q.size() != 0) @(negedge aclk);
    endtask

    task automatic report(input string what, input longint unsigned exp_v,
                          input longint unsigned got_v);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch %s: expected %0d got %0d", what, exp_v, got_v);
    endtask

    // receiver ready, with idle rate and a long hold-off when asked
    always @(negedge aclk) begin
        if (!aresetn) m_tready <= 1'b0;
        else m_tready <= !hold_recv && !(recv_idle_pct > 0 &&
                                         $urandom_range(0, 99) < recv_idle_pct);
    end

    // result checker
    always @(posedge aclk) begin
        snapshot_t e;
        int fm, fs;
        if (aresetn && m_tvalid && m_tready) begin
            if (snap_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected snapshot %h", m_tdata);
            end else begin
                e  = snap_q.pop_front();
                fm = fixed_mode_q.pop_front();
                fs = fixed_steps_q.pop_front();
                if (m_tdata[31:0] !== e.anchor_step)
                    report("anchor_step", e.anchor_step, m_tdata[31:0]);
                if (m_tdata[63:32] !== e.anchor_time_ms)
                    report("anchor_time_ms", e.anchor_time_ms, m_tdata[63:32]);
                if (m_tdata[74:64] !== e.stance_sym_x10)
                    report("stance_sym_x10", e.stance_sym_x10, m_tdata[74:64]);
                if (m_tdata[85:75] !== e.swing_sym_x10)
                    report("swing_sym_x10", e.swing_sym_x10, m_tdata[85:75]);
                if (m_tdata[96:86] !== e.rate_sym_x10)
                    report("rate_sym_x10", e.rate_sym_x10, m_tdata[96:86]);
                if (m_tdata[116:97] !== e.avg_rate_x10)
                    report("avg_rate_x10", e.avg_rate_x10, m_tdata[116:97]);
                if (m_tdata[124:117] !== e.window_steps)
                    report("window_steps", e.window_steps, m_tdata[124:117]);
                if (m_tdata[127:125] !== 3'b000)
                    report("zero fill", 0, m_tdata[127:125]);
                if (m_tuser !== e.cadence_mode)
                    report("cadence_mode", e.cadence_mode, m_tuser);
                // typed-in values from the directed table
                if (fm >= 0 && m_tuser !== 2'(fm)) report("typed cadence_mode", fm, m_tuser);
                if (fs >= 0 && m_tdata[124:117] !== 8'(fs))
                    report("typed window_steps", fs, m_tdata[124:117]);
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > LIMIT_CYCLES) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        row_t      rows[$];
        row_t      row;
        step_rec_t r;
        int unsigned step_no;
        int        drain;

        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_recv = 1'b0;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        reset_window();
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;

        // directed table: the first snapshot sees 9 seeds + 10 records,
        // the second one 9 seeds + 20 records
        for (int i = 0; i < 24; i++) begin
            row = '{default: 0};
            row.rec.step_number  = (i < 10) ? 32'(i + 9) : ((i % 2) ? 32'hFFFF_FFFF : 32'h0);
            row.rec.heel_time_ms = (i % 3 == 0) ? 32'hFFFF_FFFF : 32'(i * 400);
            row.rec.record_valid = 1'b1;
            row.has_fixed = 1'b0;
            case (i)
                0: row.rec.record_valid = 1'b0;   // invalid record ignored by sums
                1: begin
                    row.rec.stance_ms = 16'hFFFF; row.rec.swing_ms = 16'hFFFF;
                end
                2: row.rec.peak_rate_dps = 16'h8000;   // most negative rate
                3: row.rec.peak_rate_dps = 16'h7FFF;
                4: row.rec.step_rate = 16'hFFFF;
                default: begin
                    row.rec.stance_ms = 16'(300 + 7 * i);
                    row.rec.swing_ms  = 16'(200 + 3 * i);
                    row.rec.peak_rate_dps = (i % 2) ? -16'sd200 : 16'sd180;
                    row.rec.step_rate = 16'(100 + i);
                end
            endcase
            // the record that triggers the first snapshot is left out of the sums
            if (i == 9) begin
                row.rec.record_valid = 1'b0;
                row.has_fixed = 1'b1;
                row.fixed_steps = 8'd19;
            end
            if (i == 19) begin
                row.has_fixed = 1'b1;
                row.fixed_steps = 8'd29;
            end
            rows.push_back(row);
        end
        foreach (rows[i])
            send_record(rows[i].rec, -1, rows[i].has_fixed ? int'(rows[i].fixed_steps) : -1);
        wait_drained();

        // random part in three idling phases
        step_no = 100;
        for (int k = 0; k < N_RANDOM; k++) begin
            if (k == 0) begin
                send_idle_pct = 18; recv_idle_pct = 80;
            end else if (k == N_RANDOM / 3) begin
                send_idle_pct = 80; recv_idle_pct = 18;
            end else if (k == 2 * N_RANDOM / 3) begin
                send_idle_pct = 0; recv_idle_pct = 0;
                wait_drained();   // sender pauses until all results are in
            end
            if (k == N_RANDOM / 2) begin
                // long receiver hold-off while the sender keeps offering steps
                fork
                    begin
                        hold_recv = 1'b1;
                        repeat (3000) @(negedge aclk);
                        hold_recv = 1'b0;
                    end
                join_none
            end
            r = random_record(step_no);
            step_no++;
            send_record(r, -1, -1);
        end

        s_tvalid <= 1'b0;
        drain = 0;
        while (snap_q.size() != 0 && drain < 200000) begin
            @(negedge aclk);
            drain++;
        end
        repeat (300) @(negedge aclk);
        if (mismatches == 0 && snap_q.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
